// File: sv/tif_pkg.sv
// ----------------------------------------------------------------------------
// Telnet IAC filter package
// Shared byte codes, queue sizing and the command record that is passed from
// the parser to the emitter.
// ----------------------------------------------------------------------------
package tif_pkg;

   // Telnet command bytes.
   localparam logic [7:0] BYTE_IAC  = 8'hFF;
   localparam logic [7:0] BYTE_WILL = 8'hFB;
   localparam logic [7:0] BYTE_WONT = 8'hFC;
   localparam logic [7:0] BYTE_DO   = 8'hFD;
   localparam logic [7:0] BYTE_DONT = 8'hFE;
   localparam logic [7:0] BYTE_SB   = 8'hFA;
   localparam logic [7:0] BYTE_SE   = 8'hF0;

   // Command queue between parser and emitter. The depth must be a power of two.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One queued command: either a data byte for the serial side, or a
   // three-word refusal (IAC, reply verb, option) for the network side.
   typedef struct packed {
      logic       refuse;
      logic [7:0] reply;
      logic [7:0] value;
   } cmd_type;

   // Queue status seen by the parser and the emitter.
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// File: sv/tif_front.sv
// ----------------------------------------------------------------------------
// Telnet IAC filter parser
// Accepts network bytes, tracks the telnet parse state and queues a command
// for every byte that produces output.
// ----------------------------------------------------------------------------
module tif_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_func,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_link_up,
   input  tif_pkg::qstat_type qstat,
   output logic               req_stall,
   output logic               push,
   output tif_pkg::cmd_type   push_cmd
);

   typedef enum logic [2:0] {
      ST_NORMAL = 3'd0,
      ST_IAC    = 3'd1,
      ST_WILL   = 3'd2,
      ST_WONT   = 3'd3,
      ST_DO     = 3'd4,
      ST_DONT   = 3'd5,
      ST_SUB    = 3'd6,
      ST_SUBIAC = 3'd7
   } parse_state_type;

   parse_state_type parse_state_ff;
   parse_state_type parse_state_in;
   logic            accept;
   logic            emit;

   // A word is taken whenever the queue has room; a word that yields nothing
   // simply does not push.
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && emit;

   always_comb begin
      parse_state_in  = parse_state_ff;
      emit            = 1'b0;
      push_cmd.refuse = 1'b0;
      push_cmd.reply  = tif_pkg::BYTE_DONT;
      push_cmd.value  = req_rx_byte;
      if (req_func) begin
         parse_state_in = ST_NORMAL;
      end else begin
         unique case (parse_state_ff)
            ST_NORMAL: begin
               if (req_rx_byte == tif_pkg::BYTE_IAC) begin
                  parse_state_in = ST_IAC;
               end else begin
                  emit = 1'b1;
               end
            end
            ST_IAC: begin
               unique case (req_rx_byte)
                  tif_pkg::BYTE_IAC: begin
                     emit           = 1'b1;
                     parse_state_in = ST_NORMAL;
                  end
                  tif_pkg::BYTE_WILL: parse_state_in = ST_WILL;
                  tif_pkg::BYTE_WONT: parse_state_in = ST_WONT;
                  tif_pkg::BYTE_DO:   parse_state_in = ST_DO;
                  tif_pkg::BYTE_DONT: parse_state_in = ST_DONT;
                  tif_pkg::BYTE_SB:   parse_state_in = ST_SUB;
                  default:            parse_state_in = ST_NORMAL;
               endcase
            end
            ST_WILL, ST_DO: begin
               emit            = req_link_up;
               push_cmd.refuse = 1'b1;
               push_cmd.reply  = (parse_state_ff == ST_WILL) ? tif_pkg::BYTE_DONT
                                                              : tif_pkg::BYTE_WONT;
               parse_state_in  = ST_NORMAL;
            end
            ST_WONT, ST_DONT: begin
               parse_state_in = ST_NORMAL;
            end
            ST_SUB: begin
               if (req_rx_byte == tif_pkg::BYTE_IAC) begin
                  parse_state_in = ST_SUBIAC;
               end
            end
            ST_SUBIAC: begin
               // A doubled IAC keeps the parser waiting for SE.
               if (req_rx_byte == tif_pkg::BYTE_SE) begin
                  parse_state_in = ST_NORMAL;
               end else if (req_rx_byte != tif_pkg::BYTE_IAC) begin
                  parse_state_in = ST_SUB;
               end
            end
            default: parse_state_in = ST_NORMAL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_state_ff <= ST_NORMAL;
      end else if (accept) begin
         parse_state_ff <= parse_state_in;
      end
   end

endmodule

// File: sv/tif_queue.sv
// ----------------------------------------------------------------------------
// Telnet IAC filter command queue
// Small first-in first-out store of parsed commands that decouples the parser
// from the emitter.
// ----------------------------------------------------------------------------
module tif_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tif_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output tif_pkg::cmd_type   head,
   output tif_pkg::qstat_type qstat
);

   tif_pkg::cmd_type                  entry_ff [tif_pkg::QDEPTH];
   logic [tif_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [tif_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [tif_pkg::QCNT_W-1:0]        count_ff;
   logic [tif_pkg::QCNT_W-1:0]        count_in;

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == tif_pkg::QCNT_W'(tif_pkg::QDEPTH));

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("command queue read while empty");
`endif

endmodule

// File: sv/tif_back.sv
// ----------------------------------------------------------------------------
// Telnet IAC filter emitter
// Takes queued commands and drives the result channel through an output
// register, expanding a refusal into its three words.
// ----------------------------------------------------------------------------
module tif_back (
   input  logic               clock,
   input  logic               reset,
   input  tif_pkg::cmd_type   head,
   input  tif_pkg::qstat_type qstat,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_to_network,
   output logic               rsp_last
);

   typedef enum logic [1:0] {
      STEP_IAC  = 2'd0,
      STEP_VERB = 2'd1,
      STEP_OPT  = 2'd2
   } step_type;

   step_type   step_ff;
   step_type   step_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_out_byte_ff;
   logic [7:0] rsp_out_byte_in;
   logic       rsp_to_network_ff;
   logic       rsp_to_network_in;
   logic       rsp_last_ff;
   logic       rsp_last_in;
   logic       load;

   // The output register may be refilled when it is empty or being taken.
   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      step_in           = step_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_to_network_in = rsp_to_network_ff;
      rsp_last_in       = rsp_last_ff;
      pop               = 1'b0;
      if (load) begin
         rsp_valid_in = !qstat.empty;
         if (!qstat.empty) begin
            if (!head.refuse) begin
               rsp_out_byte_in   = head.value;
               rsp_to_network_in = 1'b0;
               rsp_last_in       = 1'b1;
               pop               = 1'b1;
            end else begin
               rsp_to_network_in = 1'b1;
               unique case (step_ff)
                  STEP_IAC: begin
                     rsp_out_byte_in = tif_pkg::BYTE_IAC;
                     rsp_last_in     = 1'b0;
                     step_in         = STEP_VERB;
                  end
                  STEP_VERB: begin
                     rsp_out_byte_in = head.reply;
                     rsp_last_in     = 1'b0;
                     step_in         = STEP_OPT;
                  end
                  default: begin
                     rsp_out_byte_in = head.value;
                     rsp_last_in     = 1'b1;
                     step_in         = STEP_IAC;
                     pop             = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IAC;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_to_network_ff <= rsp_to_network_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_to_network = rsp_to_network_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_mid_refusal: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_IAC) |-> (rsp_valid_ff && rsp_to_network_ff && !rsp_last_ff
                                 && !qstat.empty && head.refuse))
      else $error("refusal sequence in progress without a matching word");

   a_last_ends_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (step_ff == STEP_IAC))
      else $error("final word shown while a refusal is still open");
`endif

endmodule

// File: sv/telnet_iac_filter_refuser.sv
// ----------------------------------------------------------------------------
// Telnet IAC filter with option refusal
// Strips telnet commands from a received network byte stream, forwards clean
// data toward the serial side and answers option requests with refusals.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Word contents
// req_      in         req_valid/stall    func, rx_byte, link_up
// rsp_      out        rsp_valid/stall    out_byte, to_network, last
//
// One input word is accepted per cycle while the four-entry command queue has
// room; an accepted word passes through the command queue and then through
// the emitter's single output register. A refusal (IAC, DONT or WONT, option)
// yields three result words; req_stall rises only when the queue fills.
// Synchronous reset clears the parse state, the queue and rsp_valid.
// A stalled result word is held in the output register until it is taken.
//
module telnet_iac_filter_refuser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_rx_byte,
   input  logic       req_link_up,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_to_network,
   output logic       rsp_last
);

   // Queue traffic between the parser and the emitter.
   logic               push;
   logic               pop;
   tif_pkg::cmd_type   push_cmd;
   tif_pkg::cmd_type   head;
   tif_pkg::qstat_type qstat;

   // The parser classifies each word and pushes a command only for words that
   // produce output: a data byte, a doubled IAC, or a refusal while the link
   // is up. Restart words and swallowed commands just move the parse state.
   tif_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .req_link_up (req_link_up),
      .qstat       (qstat),
      .req_stall   (req_stall),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // The queue holds commands in order so that the two sides stall apart.
   tif_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   // The emitter turns each command into one or three result words and pops
   // it once its final word has been loaded into the output register.
   tif_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_to_network (rsp_to_network),
      .rsp_last       (rsp_last)
   );

endmodule

// File: tb/telnet_iac_filter_refuser_tb.sv
// ----------------------------------------------------------------------------
// Telnet IAC filter with option refusal: self-checking testbench
// Drives received network bytes through the filter. A directed table covers
// each telnet command, refusals with the link up and down, subnegotiation and
// parser restart. Random well-formed command sequences and noise follow.
// Each result word is checked against a cycle-free parser model or a table row.
// ----------------------------------------------------------------------------
module telnet_iac_filter_refuser_tb;

   // Parser states kept by the testbench's own copy of the filter.
   typedef enum logic [2:0] {
      PS_NORMAL, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT, PS_SUB, PS_SUB_IAC
   } parse_state_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       to_network;
      logic       last;
   } outbound_word_type;

   // One row of the directed table. Where known is set, the single data word
   // that the row yields is written out in the row itself.
   typedef struct packed {
      logic       func;
      logic [7:0] rx;
      logic       up;
      logic       known;
      logic [7:0] want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 29;
   localparam int RANDOM_WORDS  = 240;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;

   localparam stim_row_type [0:DIRECTED_ROWS-1] DIRECTED = '{
      // An escaped IAC is passed on as a single 0xFF data byte.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b1, 8'hFF},
      // WILL with the highest option byte, link up: refused with DONT.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_WILL, 1'b1, 1'b0, 8'h00},
      '{1'b0, 8'hFF,              1'b1, 1'b0, 8'h00},
      // DO with the lowest option byte, link up: refused with WONT.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_DO,   1'b1, 1'b0, 8'h00},
      '{1'b0, 8'h00,              1'b1, 1'b0, 8'h00},
      // WILL while the link is down: the option byte is eaten silently.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b0, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_WILL, 1'b0, 1'b0, 8'h00},
      '{1'b0, 8'h01,              1'b0, 1'b0, 8'h00},
      // WONT and DONT are swallowed together with their option.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_WONT, 1'b1, 1'b0, 8'h00},
      '{1'b0, 8'h01,              1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_DONT, 1'b1, 1'b0, 8'h00},
      '{1'b0, 8'hFF,              1'b1, 1'b0, 8'h00},
      // An unknown command is dropped.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, 8'hF1,              1'b1, 1'b0, 8'h00},
      // Subnegotiation: an escaped IAC stays in the after-IAC state, any
      // other byte goes back to the body, and IAC SE closes it.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_SB,   1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, 8'h7F,              1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_IAC,  1'b1, 1'b0, 8'h00},
      '{1'b0, tif_pkg::BYTE_SE,   1'b1, 1'b0, 8'h00},
      // A restart in the middle of a command puts the parser back to normal,
      // so the following byte is plain data.
      '{1'b0, tif_pkg::BYTE_IAC,  1'b0, 1'b0, 8'h00},
      '{1'b1, 8'hFF,              1'b1, 1'b0, 8'h00},
      '{1'b0, 8'h80,              1'b0, 1'b1, 8'h80}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_func = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_link_up = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_to_network;
   logic       rsp_last;

   // Words the filter still owes, oldest first.
   outbound_word_type owed_words[$];
   parse_state_type   parser_state;

   int  error_count    = 0;
   int  mismatch_count = 0;
   int  words_sent     = 0;
   bit  req_flat_out   = 1'b0;
   bit  rsp_flat_out   = 1'b0;
   int  rsp_hold       = 0;
   int  quiet_cycles   = 0;

   telnet_iac_filter_refuser u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .req_link_up    (req_link_up),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_to_network (rsp_to_network),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the parser copy by one accepted word and returns the result
   // words it causes: none, one data byte, or a three-word refusal.
   function automatic int parse_telnet_byte(input logic func, input logic [7:0] b,
                                            input logic up,
                                            output outbound_word_type [2:0] words);
      int count;
      logic [7:0] verb;
      count = 0;
      words = '0;
      if (func) begin
         parser_state = PS_NORMAL;
         return 0;
      end
      case (parser_state)
         PS_NORMAL: begin
            if (b == tif_pkg::BYTE_IAC) begin
               parser_state = PS_IAC;
            end else begin
               words[0] = '{b, 1'b0, 1'b1};
               count = 1;
            end
         end
         PS_IAC: begin
            parser_state = PS_NORMAL;
            if (b == tif_pkg::BYTE_IAC) begin
               words[0] = '{tif_pkg::BYTE_IAC, 1'b0, 1'b1};
               count = 1;
            end else if (b == tif_pkg::BYTE_WILL) begin
               parser_state = PS_WILL;
            end else if (b == tif_pkg::BYTE_WONT) begin
               parser_state = PS_WONT;
            end else if (b == tif_pkg::BYTE_DO) begin
               parser_state = PS_DO;
            end else if (b == tif_pkg::BYTE_DONT) begin
               parser_state = PS_DONT;
            end else if (b == tif_pkg::BYTE_SB) begin
               parser_state = PS_SUB;
            end
         end
         PS_WILL, PS_DO: begin
            // WILL is answered with DONT, DO with WONT, but only on a live link.
            if (up) begin
               verb = (parser_state == PS_WILL) ? tif_pkg::BYTE_DONT : tif_pkg::BYTE_WONT;
               words[0] = '{tif_pkg::BYTE_IAC, 1'b1, 1'b0};
               words[1] = '{verb, 1'b1, 1'b0};
               words[2] = '{b, 1'b1, 1'b1};
               count = 3;
            end
            parser_state = PS_NORMAL;
         end
         PS_WONT, PS_DONT: begin
            parser_state = PS_NORMAL;
         end
         PS_SUB: begin
            if (b == tif_pkg::BYTE_IAC) parser_state = PS_SUB_IAC;
         end
         default: begin
            if (b == tif_pkg::BYTE_SE) begin
               parser_state = PS_NORMAL;
            end else if (b != tif_pkg::BYTE_IAC) begin
               parser_state = PS_SUB;
            end
         end
      endcase
      return count;
   endfunction

   // Presents one word after a random gap and holds it until the filter takes
   // it. Called at a rising edge; returns at the edge of acceptance.
   task automatic send_word(input logic func, input logic [7:0] b, input logic up,
                            input logic known, input logic [7:0] want);
      int gap;
      int count;
      outbound_word_type [2:0] words;
      if ($urandom_range(0, 19) == 0) req_flat_out = ~req_flat_out;
      gap = req_flat_out ? 0 : int'($urandom_range(0, 14));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_rx_byte <= b;
      req_link_up <= up;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      count = parse_telnet_byte(func, b, up, words);
      if (known) begin
         owed_words.push_back('{want, 1'b0, 1'b1});
      end else begin
         for (int i = 0; i < count; i++) owed_words.push_back(words[i]);
      end
      words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic up);
      send_word(1'b0, b, up, 1'b0, 8'h00);
   endtask

   // One random command sequence. Most are well formed with random content;
   // the rest are restarts, broken commands and plain noise.
   task automatic send_random_sequence();
      int kind;
      int body_len;
      logic [7:0] verb;
      kind = int'($urandom_range(0, 9));
      case (kind)
         0, 1: begin
            send_byte(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));
         end
         2: begin
            send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
            send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
         end
         3, 4: begin
            // Option request; the link is mostly up so that refusals are common.
            verb = $urandom_range(0, 1) ? tif_pkg::BYTE_WILL : tif_pkg::BYTE_DO;
            send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
            send_byte(verb, 1'($urandom_range(0, 1)));
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
         end
         5: begin
            verb = $urandom_range(0, 1) ? tif_pkg::BYTE_WONT : tif_pkg::BYTE_DONT;
            send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
            send_byte(verb, 1'($urandom_range(0, 1)));
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         6: begin
            send_byte(tif_pkg::BYTE_IAC, 1'b1);
            send_byte(tif_pkg::BYTE_SB, 1'b1);
            body_len = int'($urandom_range(0, 6));
            for (int i = 0; i < body_len; i++) begin
               case ($urandom_range(0, 5))
                  0: begin
                     send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
                     send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
                  end
                  1: begin
                     send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
                     send_byte(8'($urandom_range(tif_pkg::BYTE_SE + 1, 254)),
                               1'($urandom_range(0, 1)));
                  end
                  default: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               endcase
            end
            send_byte(tif_pkg::BYTE_IAC, 1'b1);
            send_byte(tif_pkg::BYTE_SE, 1'b1);
         end
         7: begin
            send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
            send_byte(8'($urandom_range(0, 8'hF9)), 1'($urandom_range(0, 1)));
         end
         8: begin
            // A command cut short by a new connection.
            if ($urandom_range(0, 1)) send_byte(tif_pkg::BYTE_IAC, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) send_byte(tif_pkg::BYTE_SB, 1'b1);
            send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, 8'h00);
         end
         default: begin
            send_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, 8'h00);
         end
      endcase
   endtask

   // Stimulus: reset, the directed table, then random sequences, then drain.
   initial begin
      parser_state = PS_NORMAL;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_word(DIRECTED[i].func, DIRECTED[i].rx, DIRECTED[i].up,
                   DIRECTED[i].known, DIRECTED[i].want);
      end
      while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) send_random_sequence();
      req_valid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result side: random stall after each taken word, and the field checks.
   always @(posedge clock) begin
      outbound_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected word byte=%02h net=%b last=%b", $realtime,
                           rsp_out_byte, rsp_to_network, rsp_last);
               end
            end else begin
               want = owed_words.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_to_network !== want.to_network ||
                   rsp_last !== want.last) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"%0t: word mismatch expected byte=%02h net=%b last=%b,",
                               " got byte=%02h net=%b last=%b"},
                              $realtime, want.out_byte, want.to_network, want.last,
                              rsp_out_byte, rsp_to_network, rsp_last);
                  end
               end
            end
            if ($urandom_range(0, 19) == 0) rsp_flat_out = ~rsp_flat_out;
            rsp_hold = rsp_flat_out ? 0 : int'($urandom_range(0, 14));
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // Watchdog: ends the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: filelist.f
sv/tif_pkg.sv
sv/tif_front.sv
sv/tif_queue.sv
sv/tif_back.sv
sv/telnet_iac_filter_refuser.sv
tb/telnet_iac_filter_refuser_tb.sv
